### design/stt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the software timer table.
// No dependencies; imported by stt_ctrl, stt_dp and the top level.
package stt_pkg;

    localparam int SLOTS   = 16;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int COUNT_W = $clog2(SLOTS + 1);
    localparam int TIME_W  = 48;
    localparam int MS_W    = 31;
    localparam int NEXT_W  = 32;

    localparam logic [MS_W-1:0]   ID_MAX   = {MS_W{1'b1}};
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_QUERY  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_ADDED   = 3'd0,
        ST_FULL    = 3'd1,
        ST_CANCEL  = 3'd2,
        ST_FIRED   = 3'd3,
        ST_SUMMARY = 3'd4,
        ST_NEXT    = 3'd5
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic              load;
        logic              apply;
        logic              emit_fire;
        logic              emit_final;
        logic [SLOT_W-1:0] idx;
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic hit;
        logic out_free;
        t_cmd cmd;
    } t_dp_stat;

endpackage

### design/stt_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the timer table: walks the slots one per cycle per command;
// a fired slot waits for a free output register. Depends on stt_pkg.
module stt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  stt_pkg::t_dp_stat  i_stat,
    output stt_pkg::t_ctrl_cmd o_cmd
);
    import stt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINAL
    } t_state;

    t_state            r_state, n_state;
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic              w_last_slot;
    logic              w_early_done;

    assign w_last_slot  = (r_idx == SLOT_W'(SLOTS - 1));
    // add and cancel stop at the first slot that takes them
    assign w_early_done = i_stat.hit &&
                          (i_stat.cmd == CMD_ADD || i_stat.cmd == CMD_CANCEL);

    always_comb begin
        n_state          = r_state;
        n_idx            = r_idx;
        o_cmd.load       = 1'b0;
        o_cmd.apply      = 1'b0;
        o_cmd.emit_fire  = 1'b0;
        o_cmd.emit_final = 1'b0;
        o_cmd.idx        = r_idx;
        o_in_ready       = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_idx      = '0;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.cmd == CMD_TICK && i_stat.hit) begin
                    // fired word needs the output register
                    if (i_stat.out_free) begin
                        o_cmd.apply     = 1'b1;
                        o_cmd.emit_fire = 1'b1;
                        n_idx           = r_idx + 1'b1;
                        if (w_last_slot) n_state = S_FINAL;
                    end
                end else begin
                    o_cmd.apply = 1'b1;
                    n_idx       = r_idx + 1'b1;
                    if (w_early_done || w_last_slot) n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_final = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule

### design/stt_dp.sv
`timescale 1ns / 1ps
// Datapath for the timer table: slot storage, id counter, scan arithmetic
// and the output word register. Depends on stt_pkg.
module stt_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  stt_pkg::t_ctrl_cmd         i_cmd,
    output stt_pkg::t_dp_stat          o_stat,
    input  stt_pkg::t_cmd              i_in_cmd,
    input  logic [stt_pkg::TIME_W-1:0] i_now_ms,
    input  logic [stt_pkg::MS_W-1:0]   i_delay_ms,
    input  logic [stt_pkg::MS_W-1:0]   i_period_ms,
    input  logic [stt_pkg::MS_W-1:0]   i_target_id,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output stt_pkg::t_status           o_status,
    output logic [stt_pkg::MS_W-1:0]   o_timer_id,
    output logic [stt_pkg::NEXT_W-1:0] o_next_ms,
    output logic [stt_pkg::COUNT_W-1:0] o_fired_count,
    output logic                       o_last
);
    import stt_pkg::*;

    // slot table
    logic [SLOTS-1:0]  r_active;
    logic [MS_W-1:0]   r_slot_id       [SLOTS];
    logic [TIME_W-1:0] r_slot_deadline [SLOTS];
    logic [MS_W-1:0]   r_slot_period   [SLOTS];
    logic [MS_W-1:0]   r_id_counter;

    // latched command
    t_cmd              r_cmd;
    logic [TIME_W-1:0] r_now;
    logic [MS_W-1:0]   r_delay;
    logic [MS_W-1:0]   r_period;
    logic [MS_W-1:0]   r_target;

    // scan results
    logic               r_found;
    logic [MS_W-1:0]    r_new_id;
    logic               r_any;
    logic [TIME_W-1:0]  r_best;
    logic [COUNT_W-1:0] r_count;

    // output word
    logic               r_o_valid;
    t_status            r_o_status;
    logic [MS_W-1:0]    r_o_id;
    logic [NEXT_W-1:0]  r_o_next;
    logic [COUNT_W-1:0] r_o_count;
    logic               r_o_last;

    logic              w_act;
    logic [MS_W-1:0]   w_id;
    logic [TIME_W-1:0] w_dl;
    logic [MS_W-1:0]   w_per;
    logic              w_hit;
    logic              w_expired;
    logic [TIME_W:0]   w_add_sum;
    logic [TIME_W-1:0] w_add_dl;
    logic [TIME_W:0]   w_rel_sum;
    logic [TIME_W-1:0] w_rel_dl;
    logic [TIME_W-1:0] w_remain;
    logic              w_out_free;
    logic [NEXT_W-1:0] w_next_reply;

    assign w_act = r_active[i_cmd.idx];
    assign w_id  = r_slot_id[i_cmd.idx];
    assign w_dl  = r_slot_deadline[i_cmd.idx];
    assign w_per = r_slot_period[i_cmd.idx];

    assign w_expired = (w_dl <= r_now);

    always_comb begin
        unique case (r_cmd)
            CMD_ADD:    w_hit = !w_act;
            CMD_CANCEL: w_hit = w_act && (w_id == r_target);
            CMD_TICK:   w_hit = w_act && w_expired;
            CMD_QUERY:  w_hit = w_act;
        endcase
    end

    // saturating deadline sums
    assign w_add_sum = {1'b0, r_now} + {{(TIME_W + 1 - MS_W){1'b0}}, r_delay};
    assign w_add_dl  = w_add_sum[TIME_W] ? TIME_MAX : w_add_sum[TIME_W-1:0];
    assign w_rel_sum = {1'b0, r_now} + {{(TIME_W + 1 - MS_W){1'b0}}, w_per};
    assign w_rel_dl  = w_rel_sum[TIME_W] ? TIME_MAX : w_rel_sum[TIME_W-1:0];

    assign w_remain  = w_expired ? '0 : (w_dl - r_now);

    // -1 when nothing is active, else clamped to the 31-bit range
    assign w_next_reply = !r_any                      ? '1 :
                          (r_best > TIME_W'(ID_MAX))  ? NEXT_W'(ID_MAX) :
                                                        r_best[NEXT_W-1:0];

    assign w_out_free = !r_o_valid || i_out_ready;

    assign o_stat.hit      = w_hit;
    assign o_stat.out_free = w_out_free;
    assign o_stat.cmd      = r_cmd;

    // table state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= '0;
            r_id_counter <= MS_W'(1);
        end else if (i_cmd.apply && w_hit) begin
            unique case (r_cmd)
                CMD_ADD: begin
                    r_active[i_cmd.idx] <= 1'b1;
                    r_id_counter <= (r_id_counter == ID_MAX) ? MS_W'(1)
                                                             : r_id_counter + 1'b1;
                end
                CMD_CANCEL: r_active[i_cmd.idx] <= 1'b0;
                CMD_TICK: begin
                    if (w_per == '0) r_active[i_cmd.idx] <= 1'b0;
                end
                CMD_QUERY: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply && w_hit) begin
            if (r_cmd == CMD_ADD) begin
                r_slot_id[i_cmd.idx]       <= r_id_counter;
                r_slot_period[i_cmd.idx]   <= r_period;
                r_slot_deadline[i_cmd.idx] <= w_add_dl;
            end else if (r_cmd == CMD_TICK && w_per != '0) begin
                r_slot_deadline[i_cmd.idx] <= w_rel_dl;
            end
        end
    end

    // command latch and scan accumulators
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd    <= i_in_cmd;
            r_now    <= i_now_ms;
            r_delay  <= i_delay_ms;
            r_period <= i_period_ms;
            r_target <= i_target_id;
            r_found  <= 1'b0;
            r_any    <= 1'b0;
            r_count  <= '0;
        end else if (i_cmd.apply && w_hit) begin
            unique case (r_cmd)
                CMD_ADD: begin
                    r_found  <= 1'b1;
                    r_new_id <= r_id_counter;
                end
                CMD_CANCEL: ;
                CMD_TICK:   r_count <= r_count + 1'b1;
                CMD_QUERY: begin
                    if (!r_any || w_remain < r_best) r_best <= w_remain;
                    r_any <= 1'b1;
                end
            endcase
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit_fire || i_cmd.emit_final) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_fire) begin
            r_o_status <= ST_FIRED;
            r_o_id     <= w_id;
            r_o_next   <= '0;
            r_o_count  <= '0;
            r_o_last   <= 1'b0;
        end else if (i_cmd.emit_final) begin
            r_o_id    <= (r_cmd == CMD_ADD && r_found) ? r_new_id : '0;
            r_o_next  <= (r_cmd == CMD_QUERY) ? w_next_reply : '0;
            r_o_count <= (r_cmd == CMD_TICK) ? r_count : '0;
            r_o_last  <= 1'b1;
            unique case (r_cmd)
                CMD_ADD:    r_o_status <= r_found ? ST_ADDED : ST_FULL;
                CMD_CANCEL: r_o_status <= ST_CANCEL;
                CMD_TICK:   r_o_status <= ST_SUMMARY;
                CMD_QUERY:  r_o_status <= ST_NEXT;
            endcase
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_status      = r_o_status;
    assign o_timer_id    = r_o_id;
    assign o_next_ms     = r_o_next;
    assign o_fired_count = r_o_count;
    assign o_last        = r_o_last;

endmodule

### design/software_timer_table_top.sv
`timescale 1ns / 1ps
// Software timer table, top level. Depends on stt_pkg, stt_ctrl, stt_dp.
// A command visits the 16 slots one per cycle, then issues its reply word from a
// final state; the next command word is taken once that state returns to idle.
// Add and cancel stop early at the slot they hit. A fired word stalls the scan while
// the output register is full. Reset (synchronous, active low) frees every slot, id to 1.
module software_timer_table_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [143:0]  s_axis_tdata,  // now_ms, delay_ms, period_ms, target_id, pad
    input  logic [1:0]    s_axis_tuser,  // cmd
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [71:0]   m_axis_tdata,  // timer_id, next_ms, fired_count, pad
    output logic [2:0]    m_axis_tuser,  // status
    output logic          m_axis_tlast   // last word of the command
);
    import stt_pkg::*;

    t_ctrl_cmd            w_cmd;
    t_dp_stat             w_stat;
    t_status              w_status;
    logic [MS_W-1:0]      w_timer_id;
    logic [NEXT_W-1:0]    w_next_ms;
    logic [COUNT_W-1:0]   w_fired_count;

    stt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    stt_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_in_cmd      (t_cmd'(s_axis_tuser)),
        .i_now_ms      (s_axis_tdata[47:0]),
        .i_delay_ms    (s_axis_tdata[78:48]),
        .i_period_ms   (s_axis_tdata[109:79]),
        .i_target_id   (s_axis_tdata[140:110]),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_status      (w_status),
        .o_timer_id    (w_timer_id),
        .o_next_ms     (w_next_ms),
        .o_fired_count (w_fired_count),
        .o_last        (m_axis_tlast)
    );

    assign m_axis_tuser = w_status;
    assign m_axis_tdata = {4'b0, w_fired_count, w_next_ms, w_timer_id};

endmodule

### tb/software_timer_table_top_test.sv
`timescale 1ns / 1ps
// Self-checking bench for software_timer_table_top: directed table, then random commands.
// Depends on stt_pkg and the design; carries its own slot-table predictor.
module software_timer_table_top_test;
    import stt_pkg::*;

    localparam int RAND_ITEMS = 400;
    localparam int CALM_ITEMS = 60;
    localparam int DRAIN_CYC  = 40;

    typedef struct packed {
        t_status            status;
        logic [MS_W-1:0]    timer_id;
        logic [NEXT_W-1:0]  next_ms;
        logic [COUNT_W-1:0] fired_count;
        logic               last;
    } t_reply;

    typedef struct packed {
        t_cmd               cmd;
        logic [TIME_W-1:0]  now;
        logic [MS_W-1:0]    delay;
        logic [MS_W-1:0]    period;
        logic [MS_W-1:0]    target;
        logic [4:0]         reps;
        logic               typed;    // reply below is taken as the expectation
        t_status            status;
        logic [MS_W-1:0]    timer_id;
        logic [NEXT_W-1:0]  next_ms;
        logic [COUNT_W-1:0] fired_count;
    } t_row;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [143:0]  s_axis_tdata = '0;   // now_ms, delay_ms, period_ms, target_id, pad
    logic [1:0]    s_axis_tuser = '0;   // cmd
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [71:0]   m_axis_tdata;        // timer_id, next_ms, fired_count, pad
    logic [2:0]    m_axis_tuser;        // status
    logic          m_axis_tlast;

    software_timer_table_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    // predicted table
    logic              slot_on  [SLOTS];
    logic [MS_W-1:0]   slot_tid [SLOTS];
    logic [TIME_W-1:0] slot_due [SLOTS];
    logic [MS_W-1:0]   slot_ivl [SLOTS];
    logic [MS_W-1:0]   next_id;

    t_reply model_out[$];
    t_reply pending_replies[$];

    int errors = 0;
    int words_checked = 0;
    int fired_seen = 0;
    int commands_sent = 0;
    int full_seen = 0;
    bit calm = 1'b0;
    int stall_left = 0;

    function automatic t_reply reply_word(t_status st, logic [MS_W-1:0] id,
                                          logic [NEXT_W-1:0] nx, logic [COUNT_W-1:0] cnt,
                                          logic lst);
        t_reply r;
        r.status = st;
        r.timer_id = id;
        r.next_ms = nx;
        r.fired_count = cnt;
        r.last = lst;
        return r;
    endfunction

    function automatic logic [TIME_W-1:0] due_at(logic [TIME_W-1:0] now, logic [MS_W-1:0] dly);
        logic [TIME_W:0] sum;
        sum = {1'b0, now} + {{(TIME_W+1-MS_W){1'b0}}, dly};
        return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    endfunction

    function automatic void predict_replies(t_cmd cmd, logic [TIME_W-1:0] now,
                                            logic [MS_W-1:0] delay, logic [MS_W-1:0] period,
                                            logic [MS_W-1:0] target);
        logic [TIME_W-1:0] best;
        logic [TIME_W-1:0] left;
        bit                hit;
        int                n;
        model_out.delete();
        hit = 1'b0;
        best = '0;
        n = 0;
        case (cmd)
            CMD_ADD: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!hit && !slot_on[i]) begin
                        hit = 1'b1;
                        slot_on[i] = 1'b1;
                        slot_tid[i] = next_id;
                        slot_ivl[i] = period;
                        slot_due[i] = due_at(now, delay);
                        model_out.push_back(reply_word(ST_ADDED, next_id, '0, '0, 1'b1));
                        next_id = (next_id == ID_MAX) ? MS_W'(1) : next_id + 1'b1;
                    end
                end
                if (!hit)
                    model_out.push_back(reply_word(ST_FULL, '0, '0, '0, 1'b1));
            end
            CMD_CANCEL: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!hit && slot_on[i] && slot_tid[i] == target) begin
                        hit = 1'b1;
                        slot_on[i] = 1'b0;
                    end
                end
                model_out.push_back(reply_word(ST_CANCEL, '0, '0, '0, 1'b1));
            end
            CMD_TICK: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_on[i] && slot_due[i] <= now) begin
                        model_out.push_back(reply_word(ST_FIRED, slot_tid[i], '0, '0, 1'b0));
                        n++;
                        if (slot_ivl[i] == '0)
                            slot_on[i] = 1'b0;
                        else
                            slot_due[i] = due_at(now, slot_ivl[i]);
                    end
                end
                model_out.push_back(reply_word(ST_SUMMARY, '0, '0, COUNT_W'(n), 1'b1));
            end
            default: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_on[i]) begin
                        left = (slot_due[i] > now) ? slot_due[i] - now : '0;
                        if (!hit || left < best)
                            best = left;
                        hit = 1'b1;
                    end
                end
                if (!hit)
                    model_out.push_back(reply_word(ST_NEXT, '0, '1, '0, 1'b1));
                else if (best > TIME_W'(32'h7fff_ffff))
                    model_out.push_back(reply_word(ST_NEXT, '0, 32'h7fff_ffff, '0, 1'b1));
                else
                    model_out.push_back(reply_word(ST_NEXT, '0, best[NEXT_W-1:0], '0, 1'b1));
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("MISMATCH word %0d %s: got %0h expected %0h", words_checked, what, got, want);
    endtask

    // Holds one command word on the bus until accepted, then queues what it should produce.
    // A typed row supplies its own single reply; the predictor still tracks the state.
    task automatic send_command(t_cmd cmd, logic [TIME_W-1:0] now, logic [MS_W-1:0] delay,
                                logic [MS_W-1:0] period, logic [MS_W-1:0] target,
                                logic typed, t_reply hand);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {3'b000, target, period, delay, now};
        do @(posedge i_clk); while (!s_axis_tready);
        commands_sent++;
        predict_replies(cmd, now, delay, period, target);
        if (typed)
            pending_replies.push_back(hand);
        else
            foreach (model_out[j]) pending_replies.push_back(model_out[j]);
    endtask

    task automatic maybe_idle();
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    // result side: check accepted words, stall in random bursts
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_replies.size() == 0) begin
                report_mismatch("unexpected word, status", 64'(m_axis_tuser), 64'd0);
            end else begin
                want = pending_replies.pop_front();
                if (m_axis_tuser !== want.status)
                    report_mismatch("status", 64'(m_axis_tuser), 64'(want.status));
                if (m_axis_tdata[30:0] !== want.timer_id)
                    report_mismatch("timer_id", 64'(m_axis_tdata[30:0]), 64'(want.timer_id));
                if (m_axis_tdata[62:31] !== want.next_ms)
                    report_mismatch("next_ms", 64'(m_axis_tdata[62:31]), 64'(want.next_ms));
                if (m_axis_tdata[67:63] !== want.fired_count)
                    report_mismatch("fired_count", 64'(m_axis_tdata[67:63]),
                                    64'(want.fired_count));
                if (m_axis_tlast !== want.last)
                    report_mismatch("tlast", 64'(m_axis_tlast), 64'(want.last));
                if (want.status == ST_FIRED)
                    fired_seen++;
                if (want.status == ST_FULL)
                    full_seen++;
            end
            words_checked++;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        t_row              plan[22];
        t_reply            hand;
        t_cmd              cmd;
        logic [TIME_W-1:0] clock_ms;
        logic [TIME_W-1:0] now;
        logic [MS_W-1:0]   delay;
        logic [MS_W-1:0]   period;
        logic [MS_W-1:0]   target;
        logic [MS_W-1:0]   live_ids[$];
        int                roll;
        bit                noise;

        for (int i = 0; i < SLOTS; i++) begin
            slot_on[i] = 1'b0;
            slot_tid[i] = '0;
            slot_due[i] = '0;
            slot_ivl[i] = '0;
        end
        next_id = MS_W'(1);

        // cmd, now, delay, period, target, reps, typed, status, id, next, count
        plan = '{
            '{CMD_QUERY,  48'd0, 31'd0, 31'd0, 31'd0, 5'd1, 1'b1, ST_NEXT, 31'd0, 32'hffff_ffff, 5'd0},
            '{CMD_TICK,   48'd0, 31'd0, 31'd0, 31'd0, 5'd1, 1'b1, ST_SUMMARY, 31'd0, 32'd0, 5'd0},
            '{CMD_CANCEL, 48'd0, 31'd0, 31'd0, 31'd5, 5'd1, 1'b1, ST_CANCEL, 31'd0, 32'd0, 5'd0},
            '{CMD_ADD, 48'd1000, 31'd0, 31'd0, 31'd0, 5'd1, 1'b1, ST_ADDED, 31'd1, 32'd0, 5'd0},
            '{CMD_ADD, 48'd1000, ID_MAX, ID_MAX, 31'd0, 5'd1, 1'b1, ST_ADDED, 31'd2, 32'd0, 5'd0},
            // deadline past the end of the time range saturates
            '{CMD_ADD, TIME_MAX - 48'd10, 31'd100, 31'd7, 31'd0, 5'd1, 1'b1, ST_ADDED, 31'd3,
              32'd0, 5'd0},
            '{CMD_QUERY, 48'd1000, 31'd0, 31'd0, 31'd0, 5'd1, 1'b1, ST_NEXT, 31'd0, 32'd0, 5'd0},
            '{CMD_QUERY, 48'd0, 31'd0, 31'd0, 31'd0, 5'd1, 1'b0, ST_NEXT, 31'd0, 32'd0, 5'd0},
            '{CMD_TICK, 48'd1000, 31'd0, 31'd0, 31'd0, 5'd1, 1'b0, ST_SUMMARY, 31'd0, 32'd0, 5'd0},
            // remaining time beyond the 31-bit range clamps
            '{CMD_QUERY, 48'd0, 31'd0, 31'd0, 31'd0, 5'd1, 1'b0, ST_NEXT, 31'd0, 32'd0, 5'd0},
            '{CMD_CANCEL, 48'd0, 31'd0, 31'd0, 31'd2, 5'd1, 1'b1, ST_CANCEL, 31'd0, 32'd0, 5'd0},
            '{CMD_ADD, 48'd2000, 31'd5, 31'd5, 31'd0, 5'd1, 1'b1, ST_ADDED, 31'd4, 32'd0, 5'd0},
            '{CMD_QUERY, TIME_MAX, 31'd0, 31'd0, 31'd0, 5'd1, 1'b0, ST_NEXT, 31'd0, 32'd0, 5'd0},
            // fill the rest of the table, then one add too many
            '{CMD_ADD, 48'd500, 31'd50, 31'd0, 31'd0, 5'd14, 1'b0, ST_ADDED, 31'd0, 32'd0, 5'd0},
            '{CMD_ADD, 48'd500, 31'd50, 31'd0, 31'd0, 5'd1, 1'b1, ST_FULL, 31'd0, 32'd0, 5'd0},
            // every slot fires: longest reply burst
            '{CMD_TICK, TIME_MAX, 31'd0, 31'd0, 31'd0, 5'd1, 1'b0, ST_SUMMARY, 31'd0, 32'd0, 5'd0},
            '{CMD_CANCEL, 48'd0, 31'd0, 31'd0, ID_MAX, 5'd1, 1'b1, ST_CANCEL, 31'd0, 32'd0, 5'd0},
            '{CMD_CANCEL, 48'd0, 31'd0, 31'd0, 31'd3, 5'd1, 1'b0, ST_CANCEL, 31'd0, 32'd0, 5'd0},
            '{CMD_CANCEL, 48'd0, 31'd0, 31'd0, 31'd4, 5'd1, 1'b0, ST_CANCEL, 31'd0, 32'd0, 5'd0},
            '{CMD_QUERY, 48'd0, 31'd0, 31'd0, 31'd0, 5'd1, 1'b1, ST_NEXT, 31'd0, 32'hffff_ffff,
              5'd0},
            '{CMD_ADD, 48'd0, 31'd0, 31'd0, 31'd0, 5'd1, 1'b0, ST_ADDED, 31'd0, 32'd0, 5'd0},
            '{CMD_TICK, 48'd0, 31'd0, 31'd0, 31'd0, 5'd1, 1'b0, ST_SUMMARY, 31'd0, 32'd0, 5'd0}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[r]) begin
            for (int k = 0; k < plan[r].reps; k++) begin
                hand = reply_word(plan[r].status, plan[r].timer_id, plan[r].next_ms,
                                  plan[r].fired_count, 1'b1);
                send_command(plan[r].cmd, plan[r].now, plan[r].delay, plan[r].period,
                             plan[r].target, plan[r].typed, hand);
                maybe_idle();
            end
        end

        clock_ms = TIME_W'({$urandom_range(0, 255), $urandom});
        hand = '0;
        for (int k = 0; k < RAND_ITEMS; k++) begin
            calm = (k >= RAND_ITEMS - CALM_ITEMS);
            // sender holds off until the block has drained
            if (k == RAND_ITEMS / 2) begin
                s_axis_tvalid <= 1'b0;
                while (pending_replies.size() != 0) @(posedge i_clk);
            end
            roll = $urandom_range(0, 99);
            noise = ($urandom_range(0, 9) == 0);
            if (roll < 35)
                cmd = CMD_ADD;
            else if (roll < 65)
                cmd = CMD_TICK;
            else if (roll < 85)
                cmd = CMD_CANCEL;
            else
                cmd = CMD_QUERY;
            if (!noise && (cmd == CMD_TICK || cmd == CMD_QUERY))
                clock_ms = clock_ms + TIME_W'($urandom_range(0, 60));
            now = noise ? TIME_W'({$urandom, $urandom}) : clock_ms;
            delay = noise ? MS_W'($urandom) : MS_W'($urandom_range(0, 200));
            if (noise)
                period = MS_W'($urandom);
            else
                period = $urandom_range(0, 1) ? '0 : MS_W'($urandom_range(1, 120));
            live_ids.delete();
            for (int i = 0; i < SLOTS; i++)
                if (slot_on[i]) live_ids.push_back(slot_tid[i]);
            if (!noise && live_ids.size() != 0)
                target = live_ids[$urandom_range(0, live_ids.size() - 1)];
            else
                target = MS_W'($urandom);
            send_command(cmd, now, delay, period, target, 1'b0, hand);
            maybe_idle();
        end
        s_axis_tvalid <= 1'b0;

        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        $display("Covered %0d commands, %0d reply words checked", commands_sent, words_checked);
        $display("Fired words %0d, table-full replies %0d", fired_seen, full_seen);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
